[sv/lfu_cache_lru_tiebreak_core_macros.svh]
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Shared concurrent assertion forms for the LFU cache core.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LRU_TIEBREAK_CORE_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFUC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFUC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/lfuc_pkg.sv]
// ----------------------------------------------------------------------------
// LFU cache package
// Widths, codes and the command and status bundles of the LFU cache core.
// ----------------------------------------------------------------------------
`default_nettype none

package lfuc_pkg;

   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int CAP_MAX = (1 << CAP_W) - 1;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } lfuc_cmd_type;

   typedef struct packed {
      logic scan_last;
   } lfuc_status_type;

endpackage

`default_nettype wire

[sv/lfuc_ctrl.sv]
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences accept, table scan and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lfuc_ctrl
   import lfuc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  lfuc_status_type status,
   output lfuc_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.start  = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_COMMIT) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A new result replaces the old one only once the old one is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[sv/lfuc_dpath.sv]
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry memory, valid and recency cells, scan trackers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfuc_dpath
   import lfuc_pkg::*;
#(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CAP_W-1:0]         csr_wdata,
   input  logic                     req_kind,
   input  logic signed [DATA_W-1:0] req_key,
   input  logic signed [DATA_W-1:0] req_value,
   input  lfuc_cmd_type             cmd,
   output lfuc_status_type          status,
   output logic                     rsp_hit,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic                     rsp_evicted,
   output logic signed [DATA_W-1:0] rsp_evicted_key
);

   // The capacity register cannot exceed CAP_MAX, so no slot above it is used.
   localparam int SLOTS = (CAPACITY > CAP_MAX) ? CAP_MAX : CAPACITY;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};

   // Entry memory
   logic signed [DATA_W-1:0]  key_mem [SLOTS];
   logic signed [DATA_W-1:0]  val_mem [SLOTS];
   logic [COUNT_WIDTH-1:0]    use_mem [SLOTS];

   logic [SLOTS-1:0]          valid_ff;
   logic [IDX_W-1:0]          rank_ff [SLOTS];
   logic [CAP_W-1:0]          cap_ff;
   logic [CAP_W-1:0]          occ_ff;

   // Latched request
   logic                      kind_ff;
   logic signed [DATA_W-1:0]  key_ff;
   logic signed [DATA_W-1:0]  value_ff;

   // Scan pipeline
   logic [CNT_W-1:0]          cnt_ff;
   logic                      p_vld_ff;
   logic [IDX_W-1:0]          p_idx_ff;
   logic                      p_valid_ff;
   logic [IDX_W-1:0]          p_rank_ff;
   logic signed [DATA_W-1:0]  q_key_ff;
   logic signed [DATA_W-1:0]  q_val_ff;
   logic [COUNT_WIDTH-1:0]    q_use_ff;

   // Trackers
   logic                      match_ff;
   logic [IDX_W-1:0]          match_idx_ff;
   logic signed [DATA_W-1:0]  match_val_ff;
   logic [COUNT_WIDTH-1:0]    match_use_ff;
   logic [IDX_W-1:0]          match_rank_ff;
   logic                      vic_ff;
   logic [IDX_W-1:0]          vic_idx_ff;
   logic signed [DATA_W-1:0]  vic_key_ff;
   logic [COUNT_WIDTH-1:0]    vic_use_ff;
   logic [IDX_W-1:0]          vic_rank_ff;
   logic                      free_ff;
   logic [IDX_W-1:0]          free_idx_ff;

   logic                      rsp_hit_ff;
   logic signed [DATA_W-1:0]  rsp_read_value_ff;
   logic                      rsp_evicted_ff;
   logic signed [DATA_W-1:0]  rsp_evicted_key_ff;

   logic                      issue;
   logic [IDX_W-1:0]          rd_idx;
   logic                      take_match;
   logic                      take_vic;
   logic                      take_free;

   logic [CAP_W-1:0]          eff_cap;
   logic                      is_put;
   logic                      put_on;
   logic                      hit_out;
   logic                      do_evict;
   logic                      do_fill;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_idx;
   logic [IDX_W-1:0]          thr_rank;
   logic signed [DATA_W-1:0]  wr_value;
   logic [COUNT_WIDTH-1:0]    wr_use;
   logic [SLOTS-1:0]          rank_inc;

   assign issue            = (cnt_ff < CNT_W'(SLOTS));
   assign rd_idx           = cnt_ff[IDX_W-1:0];
   assign status.scan_last = (cnt_ff == CNT_W'(SLOTS));

   // Victim order: smallest use count, then the least recently touched.
   assign take_match = p_valid_ff && (q_key_ff == key_ff) && !match_ff;
   assign take_vic   = p_valid_ff && (!vic_ff || (q_use_ff < vic_use_ff) ||
                       ((q_use_ff == vic_use_ff) && (p_rank_ff > vic_rank_ff)));
   assign take_free  = !p_valid_ff && !free_ff;

   always_comb begin
      eff_cap  = (cap_ff > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : cap_ff;
      is_put   = (kind_ff == KIND_PUT);
      put_on   = is_put && (eff_cap != '0);
      hit_out  = is_put ? (put_on && match_ff) : match_ff;
      do_evict = put_on && !match_ff && (occ_ff >= eff_cap) && vic_ff;
      do_fill  = put_on && !match_ff && (occ_ff < eff_cap) && free_ff;
      wr_en    = hit_out || do_evict || do_fill;

      if (hit_out) begin
         wr_idx   = match_idx_ff;
         thr_rank = match_rank_ff;
      end else if (do_evict) begin
         wr_idx   = vic_idx_ff;
         thr_rank = vic_rank_ff;
      end else begin
         wr_idx   = free_idx_ff;
         thr_rank = vic_rank_ff;
      end

      wr_value = (hit_out && !is_put) ? match_val_ff : value_ff;
      if (!hit_out) begin
         wr_use = COUNT_WIDTH'(1);
      end else if (match_use_ff == COUNT_TOP) begin
         wr_use = match_use_ff;
      end else begin
         wr_use = match_use_ff + 1'b1;
      end
   end

   // Eviction followed by insertion in the same slot moves only the entries
   // that were more recent than the victim, just like a hit. A fill into a
   // free slot ages every valid entry.
   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         rank_inc[j] = valid_ff[j] && (IDX_W'(j) != wr_idx) &&
                       (do_fill || (rank_ff[j] < thr_rank));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         key_mem[wr_idx] <= key_ff;
         val_mem[wr_idx] <= wr_value;
         use_mem[wr_idx] <= wr_use;
      end
      if (cmd.scan && issue) begin
         q_key_ff <= key_mem[rd_idx];
         q_val_ff <= val_mem[rd_idx];
         q_use_ff <= use_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         occ_ff   <= '0;
         valid_ff <= '0;
      end else begin
         if (csr_we) cap_ff <= csr_wdata;
         if (cmd.commit && wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
            if (do_fill) occ_ff <= occ_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         for (int j = 0; j < SLOTS; j++) begin
            if (IDX_W'(j) == wr_idx) begin
               rank_ff[j] <= '0;
            end else if (rank_inc[j]) begin
               rank_ff[j] <= rank_ff[j] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
         cnt_ff   <= '0;
         p_vld_ff <= 1'b0;
         match_ff <= 1'b0;
         vic_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else if (cmd.scan) begin
         cnt_ff   <= cnt_ff + 1'b1;
         p_vld_ff <= issue;
         if (issue) begin
            p_idx_ff   <= rd_idx;
            p_valid_ff <= valid_ff[rd_idx];
            p_rank_ff  <= rank_ff[rd_idx];
         end
         if (p_vld_ff) begin
            if (take_match) begin
               match_ff      <= 1'b1;
               match_idx_ff  <= p_idx_ff;
               match_val_ff  <= q_val_ff;
               match_use_ff  <= q_use_ff;
               match_rank_ff <= p_rank_ff;
            end
            if (take_vic) begin
               vic_ff      <= 1'b1;
               vic_idx_ff  <= p_idx_ff;
               vic_key_ff  <= q_key_ff;
               vic_use_ff  <= q_use_ff;
               vic_rank_ff <= p_rank_ff;
            end
            if (take_free) begin
               free_ff     <= 1'b1;
               free_idx_ff <= p_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff         <= hit_out;
         rsp_read_value_ff  <= (!is_put && match_ff) ? match_val_ff : '0;
         rsp_evicted_ff     <= do_evict;
         rsp_evicted_key_ff <= do_evict ? vic_key_ff : '0;
      end
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

`default_nettype wire

[sv/lfu_cache_lru_tiebreak_core.sv]
// ----------------------------------------------------------------------------
// LFU cache core
// Key-value cache with least-frequently-used replacement and LRU tie break.
// ----------------------------------------------------------------------------
// Each item is a get or a put and yields exactly one result item. The block
// takes one item at a time: it accepts the item, scans every table slot of
// the entry memory (one read port, one entry per cycle) and then commits;
// the commit waits while an earlier result has not yet been taken. The
// result sits in an output register, so the next item is taken while a
// result still waits. The entry table is empty after reset with no clearing
// pass. The capacity register may be written only while the block is idle.
`default_nettype none

`include "lfu_cache_lru_tiebreak_core_macros.svh"

module lfu_cache_lru_tiebreak_core
   import lfuc_pkg::*;
#(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CAP_W-1:0]   csr_wdata,   // capacity
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,   // key [31:0], value [63:32]
   input  logic [0:0]         req_tuser,   // kind [0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,   // read_value [31:0], evicted_key [63:32]
   output logic [1:0]         rsp_tuser    // hit [0], evicted [1]
);

   lfuc_cmd_type             cmd;
   lfuc_status_type          status;
   logic signed [DATA_W-1:0] rd_value;
   logic signed [DATA_W-1:0] ev_key;
   logic                     hit;
   logic                     evicted;

   lfuc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfuc_dpath #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_kind        (req_tuser[0]),
      .req_key         (req_tdata[31:0]),
      .req_value       (req_tdata[63:32]),
      .cmd             (cmd),
      .status          (status),
      .rsp_hit         (hit),
      .rsp_read_value  (rd_value),
      .rsp_evicted     (evicted),
      .rsp_evicted_key (ev_key)
   );

   assign rsp_tdata = {ev_key, rd_value};
   assign rsp_tuser = {evicted, hit};

   `LFUC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "item accepted while a scan should be running")
   `LFUC_ASSERT_NEXT(a_scan_after_start, clock, reset, cmd.start, cmd.scan, "scan did not follow an accepted item")
   `LFUC_ASSERT_NEXT(a_scan_ends, clock, reset, cmd.scan && status.scan_last, !cmd.scan, "scan ran past the last slot")
   `LFUC_ASSERT_NEXT(a_rsp_after_commit, clock, reset, cmd.commit, rsp_tvalid, "commit did not present a result")

endmodule

`default_nettype wire
